// ===== src/sequential_list_engine_top_macros.svh =====
// Assertion macros for the sequential list engine.
// Included by files that check their own logic; no other dependencies.
`ifndef SEQUENTIAL_LIST_ENGINE_TOP_MACROS_SVH
`define SEQUENTIAL_LIST_ENGINE_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SLE_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sequential list engine check failed");

// Next-cycle implication, disabled while reset is asserted.
`define SLE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sequential list engine check failed");

`endif

// ===== src/sle_pkg.sv =====
// Shared types and constants for the sequential list engine.
// No dependencies.
package sle_pkg;

    localparam int CAPACITY_DEF = 64;
    localparam int VALUE_W      = 32;
    localparam int POS_W        = 7;
    localparam int FOUND_W      = 6;
    localparam int LEN_W        = 7;

    localparam logic [1:0] OP_FIND   = 2'd0;
    localparam logic [1:0] OP_INSERT = 2'd1;
    localparam logic [1:0] OP_DELETE = 2'd2;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_FULL      = 2'd1;
    localparam logic [1:0] ST_POSITION  = 2'd2;
    localparam logic [1:0] ST_NOT_FOUND = 2'd3;

    typedef logic signed [VALUE_W-1:0] t_elem;

    typedef struct packed {
        logic [1:0]             op;
        logic signed [VALUE_W-1:0] value;
        logic [POS_W-1:0]       position;
    } t_in;

    typedef struct packed {
        logic [1:0]         status;
        logic [FOUND_W-1:0] found_index;
        logic [LEN_W-1:0]   length;
    } t_out;

    typedef struct packed {
        logic             shift_up;
        logic             shift_down;
        logic [POS_W-1:0] position;
        t_elem            value;
    } t_cell_ctl;

endpackage

// ===== src/sle_cell.sv =====
// One storage cell of the list chain: holds one element and its match flag.
// Depends on sle_pkg.
module sle_cell #(
    parameter int IDX   = 0,
    parameter int IDX_W = 6,
    parameter int CNT_W = 7
) (
    input  logic               i_clk,
    input  sle_pkg::t_cell_ctl i_ctl,
    input  logic [CNT_W-1:0]   i_count,
    input  sle_pkg::t_elem     i_left,
    input  sle_pkg::t_elem     i_right,
    output sle_pkg::t_elem     o_elem,
    output logic               o_match
);
    import sle_pkg::*;

    localparam int CW = (IDX_W > POS_W) ? IDX_W : POS_W;
    localparam logic [CW-1:0]    L_IDX   = CW'(IDX);
    localparam logic [CNT_W-1:0] L_IDX_C = CNT_W'(IDX);

    t_elem          r_elem;
    t_elem          n_elem;
    logic           r_match;
    logic           n_match;
    logic [CW-1:0]  w_pos;

    always_comb begin
        w_pos   = CW'(i_ctl.position);
        n_elem  = r_elem;
        n_match = (r_elem == i_ctl.value) && (L_IDX_C < i_count);
        if (i_ctl.shift_up) begin
            if (L_IDX > w_pos) begin
                n_elem = i_left;
            end else if (L_IDX == w_pos) begin
                n_elem = i_ctl.value;
            end
        end else if (i_ctl.shift_down && (L_IDX >= w_pos)) begin
            n_elem = i_right;
        end
    end

    always_ff @(posedge i_clk) begin
        r_elem  <= n_elem;
        r_match <= n_match;
    end

    assign o_elem  = r_elem;
    assign o_match = r_match;

endmodule

// ===== src/sequential_list_engine_top.sv =====
// Sequential list engine: chain of element cells, operation decode, find encoder.
// Depends on sle_pkg, sle_cell and sequential_list_engine_top_macros.svh.
//
//  channel | valid       | ready       | payload
//  --------+-------------+-------------+---------------------------
//  in      | i_in_valid  | o_in_ready  | i_in_data  (sle_pkg::t_in)
//  out     | o_out_valid | i_out_ready | o_out_data (sle_pkg::t_out)
//
// Insert and delete shift all cells in parallel; their result, as for unused codes, is registered.
// Find: cells register their compare flags, then in S_FIND a lowest-match
// encoder over CAPACITY flags forms the index; input is held off in S_FIND.
// Reset clears the count, state and output valid; element contents are left as they are.
// A result waits in an output register; a new transaction is taken when the state is
// S_IDLE and that register is empty or drains in the same cycle.
`include "sequential_list_engine_top_macros.svh"

module sequential_list_engine_top #(
    parameter int CAPACITY = sle_pkg::CAPACITY_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  sle_pkg::t_in  i_in_data,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output sle_pkg::t_out o_out_data
);
    import sle_pkg::*;

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int IDX_W = $clog2(CAPACITY);
    localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;
    localparam int FI_W  = (IDX_W > FOUND_W) ? IDX_W : FOUND_W;
    localparam int LN_W  = (CNT_W > LEN_W) ? CNT_W : LEN_W;
    localparam logic [CNT_W-1:0] L_CAP = CNT_W'(CAPACITY);

    typedef enum logic {S_IDLE, S_FIND} t_state;

    t_state              r_state;
    logic [CNT_W-1:0]    r_count;
    logic [CNT_W-1:0]    n_count;
    t_out                r_out;
    t_out                n_res;
    logic                r_out_valid;
    logic                n_out_valid;
    logic                w_in_fire;
    logic                w_find_fire;
    logic                w_reject_fire;
    t_cell_ctl           w_ctl;
    t_elem               w_elem [CAPACITY];
    logic [CAPACITY-1:0] w_match;
    logic [CAPACITY-1:0] w_low;
    logic [FI_W-1:0]     w_idx;
    t_out                w_find;
    logic [CMP_W-1:0]    w_pos_c;
    logic [CMP_W-1:0]    w_cnt_c;
    logic [LN_W-1:0]     w_len_new;
    logic [LN_W-1:0]     w_len_cur;

    assign o_in_ready    = (r_state == S_IDLE) && (!r_out_valid || i_out_ready);
    assign w_in_fire     = i_in_valid && o_in_ready;
    assign w_find_fire   = w_in_fire && (i_in_data.op == OP_FIND);
    assign w_reject_fire = w_in_fire && (i_in_data.op != OP_FIND) && (n_res.status != ST_OK);

    always_comb begin
        w_pos_c            = CMP_W'(i_in_data.position);
        w_cnt_c            = CMP_W'(r_count);
        n_count            = r_count;
        n_res.status       = ST_OK;
        n_res.found_index  = '0;
        w_ctl.shift_up     = 1'b0;
        w_ctl.shift_down   = 1'b0;
        w_ctl.position     = i_in_data.position;
        w_ctl.value        = i_in_data.value;
        unique case (i_in_data.op)
            OP_INSERT: begin
                if (r_count >= L_CAP) begin
                    n_res.status = ST_FULL;
                end else if (w_pos_c > w_cnt_c) begin
                    n_res.status = ST_POSITION;
                end else begin
                    w_ctl.shift_up = w_in_fire;
                    n_count        = r_count + 1'b1;
                end
            end
            OP_DELETE: begin
                if (w_pos_c >= w_cnt_c) begin
                    n_res.status = ST_POSITION;
                end else begin
                    w_ctl.shift_down = w_in_fire;
                    n_count          = r_count - 1'b1;
                end
            end
            default: ;
        endcase
        w_len_new    = LN_W'(n_count);
        n_res.length = w_len_new[LEN_W-1:0];
    end

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        t_elem w_left;
        t_elem w_right;
        if (g == 0) begin : g_first
            assign w_left = w_ctl.value;
        end else begin : g_mid_l
            assign w_left = w_elem[g-1];
        end
        if (g == CAPACITY - 1) begin : g_last
            assign w_right = w_elem[g];
        end else begin : g_mid_r
            assign w_right = w_elem[g+1];
        end
        sle_cell #(
            .IDX   (g),
            .IDX_W (IDX_W),
            .CNT_W (CNT_W)
        ) u_cell (
            .i_clk   (i_clk),
            .i_ctl   (w_ctl),
            .i_count (r_count),
            .i_left  (w_left),
            .i_right (w_right),
            .o_elem  (w_elem[g]),
            .o_match (w_match[g])
        );
    end

    always_comb begin
        w_low = w_match & (~w_match + 1'b1);
        w_idx = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            if (w_low[i]) begin
                w_idx = w_idx | FI_W'(i);
            end
        end
        w_len_cur          = LN_W'(r_count);
        w_find.status      = (|w_match) ? ST_OK : ST_NOT_FOUND;
        w_find.found_index = w_idx[FOUND_W-1:0];
        w_find.length      = w_len_cur[LEN_W-1:0];
    end

    always_comb begin
        n_out_valid = r_out_valid && !i_out_ready;
        if ((r_state == S_FIND) || (w_in_fire && !w_find_fire)) begin
            n_out_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_count     <= '0;
        end else begin
            r_out_valid <= n_out_valid;
            unique case (r_state)
                S_IDLE: begin
                    if (w_find_fire) begin
                        r_state <= S_FIND;
                    end else if (w_in_fire) begin
                        r_out   <= n_res;
                        r_count <= n_count;
                    end
                end
                S_FIND: begin
                    r_out   <= w_find;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    `SLE_ASSERT_NOW(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= L_CAP)
    `SLE_ASSERT_NEXT(a_find_phase, i_clk, i_rst_n, w_find_fire, (r_state == S_FIND) && !r_out_valid)
    `SLE_ASSERT_NEXT(a_reject_hold, i_clk, i_rst_n, w_reject_fire, $stable(r_count))

endmodule
